[rtl/mtc_pkg.sv]
package mtc_pkg;

  localparam int unsigned FN_W          = 31;
  localparam int unsigned FRAME_RATE_W  = 5;
  localparam int unsigned RATE_CODE_W   = 2;
  localparam int unsigned CFG_DATA_W    = 5;
  localparam int unsigned CFG_INDEX_W   = 1;
  localparam int unsigned SPLIT_STAGES  = 6;
  localparam int unsigned SPLIT_CNT_W   = 3;
  localparam int unsigned DEF_QUEUE_DEPTH = 4;

  localparam logic [FRAME_RATE_W-1:0] FRAME_RATE_RST = 5'd25;
  localparam logic [RATE_CODE_W-1:0]  RATE_CODE_RST  = 2'd1;

  // MIDI bytes
  localparam logic [7:0] QF_STATUS    = 8'hF1;
  localparam logic [7:0] SYSEX_START  = 8'hF0;
  localparam logic [7:0] UNIVERSAL_RT = 8'h7F;
  localparam logic [7:0] MTC_SUB_ID   = 8'h01;
  localparam logic [7:0] FULL_FRAME   = 8'h01;
  localparam logic [7:0] SYSEX_END    = 8'hF7;

  // floor(x / 60) = (x * M60) >> 37 for x < 2^32
  localparam logic [31:0] M60       = 32'h8888_8889;
  localparam int unsigned M60_SHIFT = 37;
  // floor(x / 3) = (x * M3) >> 20 for x < 2^18
  localparam logic [18:0] M3        = 19'h5_5556;
  localparam int unsigned M3_SHIFT  = 20;

  localparam logic [3:0] QF_LAST_IDX = 4'd15;
  localparam logic [3:0] FF_LAST_IDX = 4'd9;

  typedef enum logic {
    OP_QUARTER = 1'b0,
    OP_FULL    = 1'b1
  } op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FRAME_RATE = 1'b0,
    CFG_RATE_CODE  = 1'b1
  } cfg_index_t;

  typedef struct packed {
    op_t         op;
    logic [4:0]  ff;
    logic [30:0] quo;
  } div_res_t;

  typedef struct packed {
    op_t        op;
    logic [4:0] ff;
    logic [5:0] ss;
    logic [5:0] mm;
    logic [4:0] hh;
  } mtc_time_t;

endpackage

[rtl/mtc_in_if.sv]
interface mtc_in_if import mtc_pkg::*; ;
  logic            valid;
  logic            ready;
  logic            operation;
  logic [FN_W-1:0] frame_number;

  modport source (output valid, output operation, output frame_number, input ready);
  modport sink   (input valid, input operation, input frame_number, output ready);
endinterface

[rtl/mtc_out_if.sv]
interface mtc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] midi_byte;
  logic       message_start;
  logic       last;

  modport source (output valid, output midi_byte, output message_start, output last,
                  input ready);
  modport sink   (input valid, input midi_byte, input message_start, input last,
                  output ready);
endinterface

[rtl/mtc_divider.sv]
module mtc_divider import mtc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  mtc_in_if.sink                  frame_ch,
  input  logic [FRAME_RATE_W-1:0] frame_rate,
  input  logic [CNT_W-1:0]        fifo_count,
  input  logic [SPLIT_CNT_W-1:0]  split_cnt,
  output logic                    res_valid,
  output div_res_t                res
);

  localparam int unsigned SUM_W = CNT_W + SPLIT_CNT_W;

  logic        busy;
  logic [3:0]  step;
  logic [31:0] num;
  logic [31:0] quo;
  logic [4:0]  rem;
  op_t         op;

  logic [6:0]  r7, d1, d2, d3, rn;
  logic [1:0]  qd;
  logic [31:0] quo_next;
  logic [SUM_W-1:0] used;
  logic        last_step, room, accept, start;

  // radix-4 restoring step: two quotient bits per cycle
  always_comb begin
    r7 = {rem, num[31:30]};
    d1 = {2'b00, frame_rate};
    d2 = {1'b0, frame_rate, 1'b0};
    d3 = d1 + d2;
    if (r7 >= d3) begin
      qd = 2'd3;
      rn = r7 - d3;
    end else if (r7 >= d2) begin
      qd = 2'd2;
      rn = r7 - d2;
    end else if (r7 >= d1) begin
      qd = 2'd1;
      rn = r7 - d1;
    end else begin
      qd = 2'd0;
      rn = r7;
    end
    quo_next = {quo[29:0], qd};
  end

  // credit check: every item in flight owns a queue slot
  always_comb begin
    used = SUM_W'(fifo_count) + SUM_W'(split_cnt) + SUM_W'(busy) + SUM_W'(res_valid);
    room = used < SUM_W'(QUEUE_DEPTH);
  end

  assign last_step      = busy && (step == 4'd15);
  assign frame_ch.ready = room && (!busy || last_step);
  assign accept         = frame_ch.valid && frame_ch.ready;
  assign start          = accept && (frame_rate != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= last_step;
      if (start) begin
        busy <= 1'b1;
      end else if (last_step) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (last_step) begin
      res.op  <= op;
      res.ff  <= rn[4:0];
      res.quo <= quo_next[30:0];
    end
    if (start) begin
      step <= 4'd0;
      num  <= {1'b0, frame_ch.frame_number};
      quo  <= '0;
      rem  <= '0;
      op   <= op_t'(frame_ch.operation);
    end else if (busy) begin
      step <= step + 4'd1;
      num  <= {num[29:0], 2'b00};
      quo  <= quo_next;
      rem  <= rn[4:0];
    end
  end

endmodule

[rtl/mtc_split.sv]
module mtc_split import mtc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  div_res_t               in_res,
  output logic                   out_valid,
  output mtc_time_t              out_time,
  output logic [SPLIT_CNT_W-1:0] cnt
);

  logic [SPLIT_STAGES-1:0] pv;

  // stage 1
  op_t         op1;
  logic [4:0]  ff1;
  logic [30:0] q1;
  logic [62:0] p1;
  // stage 2
  op_t         op2;
  logic [4:0]  ff2;
  logic [25:0] mt2;
  logic [5:0]  ss2;
  // stage 3
  op_t         op3;
  logic [4:0]  ff3;
  logic [5:0]  ss3;
  logic [25:0] mt3;
  logic [57:0] p2;
  // stage 4
  op_t         op4;
  logic [4:0]  ff4;
  logic [5:0]  ss4;
  logic [5:0]  mm4;
  logic [20:0] ht4;
  // stage 5
  op_t         op5;
  logic [4:0]  ff5;
  logic [5:0]  ss5;
  logic [5:0]  mm5;
  logic [20:0] ht5;
  logic [36:0] p3;

  logic [25:0] mt_c;
  logic [31:0] mt_x60;
  logic [20:0] ht_c;
  logic [26:0] ht_x60;
  logic [16:0] dq_c;
  logic [21:0] dq_x24;

  always_comb begin
    mt_c   = p1[M60_SHIFT +: 26];
    mt_x60 = {mt_c, 6'b0} - {4'b0, mt_c, 2'b0};
    ht_c   = p2[M60_SHIFT +: 21];
    ht_x60 = {ht_c, 6'b0} - {4'b0, ht_c, 2'b0};
    dq_c   = p3[M3_SHIFT +: 17];
    dq_x24 = {1'b0, dq_c, 4'b0} + {2'b0, dq_c, 3'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else begin
      pv <= {pv[SPLIT_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    op1 <= in_res.op;
    ff1 <= in_res.ff;
    q1  <= in_res.quo;
    p1  <= in_res.quo * M60;

    op2 <= op1;
    ff2 <= ff1;
    mt2 <= mt_c;
    ss2 <= q1[5:0] - mt_x60[5:0];

    op3 <= op2;
    ff3 <= ff2;
    ss3 <= ss2;
    mt3 <= mt2;
    p2  <= mt2 * M60;

    op4 <= op3;
    ff4 <= ff3;
    ss4 <= ss3;
    mm4 <= mt3[5:0] - ht_x60[5:0];
    ht4 <= ht_c;

    // hours mod 24: divide by 8, then by 3
    op5 <= op4;
    ff5 <= ff4;
    ss5 <= ss4;
    mm5 <= mm4;
    ht5 <= ht4;
    p3  <= ht4[20:3] * M3;

    out_time.op <= op5;
    out_time.ff <= ff5;
    out_time.ss <= ss5;
    out_time.mm <= mm5;
    out_time.hh <= ht5[4:0] - dq_x24[4:0];
  end

  assign out_valid = pv[SPLIT_STAGES-1];
  assign cnt       = SPLIT_CNT_W'($countones(pv));

endmodule

[rtl/mtc_fifo.sv]
module mtc_fifo import mtc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mtc_time_t        din,
  input  logic             pop,
  output mtc_time_t        dout,
  output logic             not_empty,
  output logic [CNT_W-1:0] count
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  mtc_time_t        mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  // upstream credit check keeps pushes within depth
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  assign dout      = mem[rd_ptr];
  assign not_empty = (count != '0);

endmodule

[rtl/mtc_emitter.sv]
module mtc_emitter import mtc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [RATE_CODE_W-1:0] rate_code,
  input  logic                   has_entry,
  input  mtc_time_t              entry,
  output logic                   pop,
  mtc_out_if.source              midi_ch
);

  typedef enum logic [2:0] {
    PC_FRAME_LO  = 3'd0,
    PC_FRAME_HI  = 3'd1,
    PC_SEC_LO    = 3'd2,
    PC_SEC_HI    = 3'd3,
    PC_MIN_LO    = 3'd4,
    PC_MIN_HI    = 3'd5,
    PC_HOUR_LO   = 3'd6,
    PC_HOUR_HI   = 3'd7
  } piece_t;

  logic       active;
  logic [3:0] idx;
  mtc_time_t  cur;
  logic       ovalid;

  logic [7:0] byte_c;
  logic [3:0] nib;
  logic       start_c;
  logic       fin;
  logic       adv;

  always_comb begin
    nib     = '0;
    byte_c  = SYSEX_END;
    start_c = 1'b0;
    case (cur.op)
      OP_QUARTER: begin
        case (piece_t'(idx[3:1]))
          PC_FRAME_LO: nib = cur.ff[3:0];
          PC_FRAME_HI: nib = {3'b0, cur.ff[4]};
          PC_SEC_LO:   nib = cur.ss[3:0];
          PC_SEC_HI:   nib = {2'b0, cur.ss[5:4]};
          PC_MIN_LO:   nib = cur.mm[3:0];
          PC_MIN_HI:   nib = {2'b0, cur.mm[5:4]};
          PC_HOUR_LO:  nib = cur.hh[3:0];
          PC_HOUR_HI:  nib = {1'b0, rate_code, cur.hh[4]};
          default:     nib = '0;
        endcase
        if (!idx[0]) begin
          byte_c  = QF_STATUS;
          start_c = 1'b1;
        end else begin
          byte_c = {1'b0, idx[3:1], nib};
        end
        fin = (idx == QF_LAST_IDX);
      end
      default: begin
        case (idx)
          4'd0: begin
            byte_c  = SYSEX_START;
            start_c = 1'b1;
          end
          4'd1, 4'd2: byte_c = UNIVERSAL_RT;
          4'd3:       byte_c = MTC_SUB_ID;
          4'd4:       byte_c = FULL_FRAME;
          4'd5:       byte_c = {1'b0, rate_code, cur.hh};
          4'd6:       byte_c = {2'b0, cur.mm};
          4'd7:       byte_c = {2'b0, cur.ss};
          4'd8:       byte_c = {3'b0, cur.ff};
          default:    byte_c = SYSEX_END;
        endcase
        fin = (idx == FF_LAST_IDX);
      end
    endcase
  end

  // next entry loads on the cycle of the final byte, so items run back to back
  assign adv = !ovalid || midi_ch.ready;
  assign pop = adv && (!active || fin) && has_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      ovalid <= 1'b0;
    end else if (adv) begin
      ovalid <= active;
      if (!active || fin) begin
        active <= has_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= entry;
      idx <= 4'd0;
    end else if (adv && active) begin
      idx <= idx + 4'd1;
    end
    if (adv && active) begin
      midi_ch.midi_byte     <= byte_c;
      midi_ch.message_start <= start_c;
      midi_ch.last          <= fin;
    end
  end

  assign midi_ch.valid = ovalid;

endmodule

[rtl/midi_timecode_message_generator.sv]
// MIDI Time Code generator. Each frame_ch transfer carries an absolute frame number and an
// operation: quarter-frame (eight F1 messages, 16 bytes) or full-frame SysEx (10 bytes).
// midi_ch delivers one byte per transfer with message_start on the first byte of each message and last
// on the final byte of the item. A frame_rate of zero drops items without output.
// The frame-rate divider retires two quotient bits a cycle and can take the next item
// while it finishes the last one, if the queue has room; the byte stage sends one byte a
// cycle while midi_ch is ready. Configure only while idle.
module midi_timecode_message_generator import mtc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  mtc_in_if.sink                 frame_ch,
  mtc_out_if.source              midi_ch,
  input  logic                   write_enable,
  input  logic [CFG_INDEX_W-1:0] write_index,
  input  logic [CFG_DATA_W-1:0]  write_data
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [FRAME_RATE_W-1:0] frame_rate;
  logic [RATE_CODE_W-1:0]  rate_code;

  logic                   div_valid;
  div_res_t               div_res;
  logic                   split_valid;
  mtc_time_t              split_time;
  logic [SPLIT_CNT_W-1:0] split_cnt;
  mtc_time_t              head;
  logic                   head_valid;
  logic                   pop;
  logic [CNT_W-1:0]       fifo_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rate <= FRAME_RATE_RST;
      rate_code  <= RATE_CODE_RST;
    end else if (write_enable) begin
      case (cfg_index_t'(write_index))
        CFG_FRAME_RATE: frame_rate <= write_data[FRAME_RATE_W-1:0];
        CFG_RATE_CODE:  rate_code  <= write_data[RATE_CODE_W-1:0];
        default: ;
      endcase
    end
  end

  mtc_divider #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_divider (
    .clk        (clk),
    .rst        (rst),
    .frame_ch   (frame_ch),
    .frame_rate (frame_rate),
    .fifo_count (fifo_count),
    .split_cnt  (split_cnt),
    .res_valid  (div_valid),
    .res        (div_res)
  );

  mtc_split u_split (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_valid),
    .in_res    (div_res),
    .out_valid (split_valid),
    .out_time  (split_time),
    .cnt       (split_cnt)
  );

  mtc_fifo #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (split_valid),
    .din       (split_time),
    .pop       (pop),
    .dout      (head),
    .not_empty (head_valid),
    .count     (fifo_count)
  );

  mtc_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .rate_code (rate_code),
    .has_entry (head_valid),
    .entry     (head),
    .pop       (pop),
    .midi_ch   (midi_ch)
  );

endmodule

[tb/sv/mtc_checker.sv]
`timescale 1ns / 1ps

module mtc_checker import mtc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  mtc_in_if                      frame_ch,
  mtc_out_if                     midi_ch,
  input  logic                   write_enable,
  input  logic [CFG_INDEX_W-1:0] write_index,
  input  logic [CFG_DATA_W-1:0]  write_data,
  input  logic                   done,
  output int                     fail_count,
  output int                     pending,
  output int                     byte_count
);

  typedef struct packed {
    logic [7:0] midi_byte;
    logic       message_start;
    logic       last;
  } midi_beat_t;

  midi_beat_t                expected_bytes[$];
  midi_beat_t                next_beat;
  logic [FRAME_RATE_W-1:0]   rate_fps;
  logic [RATE_CODE_W-1:0]    mtc_rate_code;
  logic                      done_seen;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
    fail_count = fail_count + 1;
  endtask

  // Splits the frame count into hh:mm:ss:ff and queues the bytes of one item.
  function automatic void predict_timecode(input op_t op, input logic [FN_W-1:0] fn);
    int unsigned frames, secs, mins, hours;
    logic [7:0]  hour_byte;
    logic [3:0]  nibble;
    midi_beat_t  burst[$];
    if (rate_fps == 0) return;
    frames    = 32'(fn) % 32'(rate_fps);
    secs      = 32'(fn) / 32'(rate_fps);
    mins      = secs / 60;
    secs      = secs % 60;
    hours     = (mins / 60) % 24;
    mins      = mins % 60;
    hour_byte = {1'b0, mtc_rate_code, hours[4:0]};
    if (op == OP_QUARTER) begin
      for (int piece = 0; piece < 8; piece++) begin
        case (piece)
          0: nibble = frames[3:0];
          1: nibble = frames[7:4];
          2: nibble = secs[3:0];
          3: nibble = secs[7:4];
          4: nibble = mins[3:0];
          5: nibble = mins[7:4];
          6: nibble = hour_byte[3:0];
          default: nibble = {1'b0, mtc_rate_code, hour_byte[4]};
        endcase
        burst.push_back('{QF_STATUS, 1'b1, 1'b0});
        burst.push_back('{{1'b0, 3'(piece), nibble}, 1'b0, 1'b0});
      end
    end else begin
      burst.push_back('{SYSEX_START, 1'b1, 1'b0});
      burst.push_back('{UNIVERSAL_RT, 1'b0, 1'b0});
      burst.push_back('{UNIVERSAL_RT, 1'b0, 1'b0});
      burst.push_back('{MTC_SUB_ID, 1'b0, 1'b0});
      burst.push_back('{FULL_FRAME, 1'b0, 1'b0});
      burst.push_back('{hour_byte, 1'b0, 1'b0});
      burst.push_back('{8'(mins), 1'b0, 1'b0});
      burst.push_back('{8'(secs), 1'b0, 1'b0});
      burst.push_back('{8'(frames), 1'b0, 1'b0});
      burst.push_back('{SYSEX_END, 1'b0, 1'b0});
    end
    burst[burst.size()-1].last = 1'b1;
    foreach (burst[i]) expected_bytes.push_back(burst[i]);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      expected_bytes.delete();
      rate_fps      = FRAME_RATE_RST;
      mtc_rate_code = RATE_CODE_RST;
      done_seen     = 1'b0;
      fail_count    = 0;
      byte_count    = 0;
    end else begin
      if (write_enable) begin
        case (cfg_index_t'(write_index))
          CFG_FRAME_RATE: rate_fps = write_data[FRAME_RATE_W-1:0];
          CFG_RATE_CODE:  mtc_rate_code = write_data[RATE_CODE_W-1:0];
          default: ;
        endcase
      end
      if (frame_ch.valid && frame_ch.ready)
        predict_timecode(op_t'(frame_ch.operation), frame_ch.frame_number);
      if (midi_ch.valid && midi_ch.ready) begin
        byte_count = byte_count + 1;
        if (expected_bytes.size() == 0) begin
          report_mismatch("byte with nothing expected", midi_ch.midi_byte, 0);
        end else begin
          next_beat = expected_bytes.pop_front();
          if (midi_ch.midi_byte !== next_beat.midi_byte)
            report_mismatch("midi_byte", midi_ch.midi_byte, next_beat.midi_byte);
          if (midi_ch.message_start !== next_beat.message_start)
            report_mismatch("message_start", midi_ch.message_start, next_beat.message_start);
          if (midi_ch.last !== next_beat.last)
            report_mismatch("last", midi_ch.last, next_beat.last);
        end
      end
      if (done && !done_seen) begin
        done_seen = 1'b1;
        if (expected_bytes.size() != 0)
          report_mismatch("bytes never delivered", expected_bytes.size(), 0);
      end
    end
    pending = expected_bytes.size();
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import mtc_pkg::*;

  localparam int ITEMS_PER_PHASE = 45;
  localparam int HOLD_CYCLES     = 400;
  localparam int QUIET_CYCLES    = 80;
  localparam int END_CYCLES      = 60;
  localparam int WATCHDOG_LIMIT  = 2000;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   write_enable;
  logic [CFG_INDEX_W-1:0] write_index;
  logic [CFG_DATA_W-1:0]  write_data;
  logic                   done;
  int                     fail_count;
  int                     pending;
  int                     byte_count;

  int   send_idle_pct = 0;
  int   stall_pct     = 0;
  int   items_sent    = 0;
  int   full_sent     = 0;
  int   settings_used = 0;
  int   fps_now       = FRAME_RATE_RST;
  logic hold_trigger  = 1'b0;
  logic hold_seen     = 1'b0;
  int   hold_left     = 0;
  int   idle_cycles   = 0;

  mtc_in_if  frame_if ();
  mtc_out_if midi_if ();

  midi_timecode_message_generator uut (
    .clk          (clk),
    .rst          (rst),
    .frame_ch     (frame_if),
    .midi_ch      (midi_if),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data)
  );

  mtc_checker timecode_check (
    .clk          (clk),
    .rst          (rst),
    .frame_ch     (frame_if),
    .midi_ch      (midi_if),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .done         (done),
    .fail_count   (fail_count),
    .pending      (pending),
    .byte_count   (byte_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Output side: random stalls, plus a long hold-off when the trigger toggles.
  always @(negedge clk) begin
    if (hold_trigger != hold_seen) begin
      hold_seen     <= hold_trigger;
      hold_left     <= HOLD_CYCLES;
      midi_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      midi_if.ready <= 1'b0;
    end else begin
      midi_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (frame_if.valid && frame_if.ready) || (midi_if.valid && midi_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", idle_cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Starts and ends at a falling edge; valid stays high into the next call.
  task automatic send_frame(input op_t op, input logic [FN_W-1:0] fn);
    while ($urandom_range(99) < send_idle_pct) begin
      frame_if.valid <= 1'b0;
      @(negedge clk);
    end
    frame_if.valid        <= 1'b1;
    frame_if.operation    <= op;
    frame_if.frame_number <= fn;
    @(posedge clk);
    while (!frame_if.ready) @(posedge clk);
    items_sent = items_sent + 1;
    if (op == OP_FULL) full_sent = full_sent + 1;
    @(negedge clk);
  endtask

  task automatic drain();
    frame_if.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Items dropped at zero rate leave no trace in pending, so add a quiet gap.
  task automatic settle();
    drain();
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic set_timecode_rate(input logic [4:0] fps, input logic [4:0] code_word);
    write_enable <= 1'b1;
    write_index  <= CFG_FRAME_RATE;
    write_data   <= fps;
    @(negedge clk);
    write_index  <= CFG_RATE_CODE;
    write_data   <= code_word;
    @(negedge clk);
    write_enable <= 1'b0;
    fps_now       = fps;
    settings_used = settings_used + 1;
  endtask

  function automatic logic [FN_W-1:0] pick_frame_number();
    longint unsigned day;
    day = longint'(fps_now) * 86400;
    case ($urandom_range(3))
      0: return FN_W'($urandom);
      1: return FN_W'($urandom_range(100000));
      // lands around a midnight boundary so hours wrap
      2: return FN_W'(day * $urandom_range(1, 800) - fps_now + $urandom_range(2 * fps_now));
      default: return {FN_W{1'b1}} - FN_W'($urandom_range(5000));
    endcase
  endfunction

  initial begin
    rst                   = 1'b1;
    done                  = 1'b0;
    write_enable          = 1'b0;
    write_index           = CFG_FRAME_RATE;
    write_data            = '0;
    frame_if.valid        = 1'b0;
    frame_if.operation    = OP_QUARTER;
    frame_if.frame_number = '0;
    midi_if.ready         = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: 25 fps, rate code 1
    send_frame(OP_QUARTER, '0);
    send_frame(OP_FULL, '0);
    send_frame(OP_QUARTER, {FN_W{1'b1}});
    send_frame(OP_FULL, {FN_W{1'b1}});
    send_frame(OP_QUARTER, 31'd2159999);
    send_frame(OP_FULL, 31'd2159999);
    send_frame(OP_FULL, 31'd2160000);
    send_frame(OP_QUARTER, 31'h2AAA_AAAA);
    send_frame(OP_FULL, 31'h5555_5555);
    send_frame(OP_QUARTER, 31'd24);

    settle();
    set_timecode_rate(5'd30, 5'd3);
    send_frame(OP_QUARTER, {FN_W{1'b1}});
    send_frame(OP_FULL, 31'd2591999);

    // rate above 30 is taken as is
    settle();
    set_timecode_rate(5'd31, 5'd2);
    send_frame(OP_FULL, {FN_W{1'b1}});
    send_frame(OP_QUARTER, 31'd111599);

    settle();
    set_timecode_rate(5'd1, 5'd0);
    send_frame(OP_QUARTER, {FN_W{1'b1}});
    send_frame(OP_FULL, 31'd86399);

    // zero rate: both operations must stay silent
    settle();
    set_timecode_rate(5'd0, 5'd1);
    send_frame(OP_QUARTER, '0);
    send_frame(OP_FULL, {FN_W{1'b1}});

    for (int phase = 0; phase < 4; phase++) begin
      settle();
      // upper bits of the rate code word are don't-care
      set_timecode_rate(5'($urandom_range(1, 31)), 5'($urandom));
      send_idle_pct = (phase == 1) ? 64 : (phase == 3) ? 36 : 0;
      stall_pct    <= (phase == 2) ? 64 : (phase == 3) ? 36 : 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 0 && n == 6) hold_trigger <= ~hold_trigger;
        if (phase == 1 && n == 20) drain();
        send_frame(op_t'($urandom_range(1)), pick_frame_number());
      end
    end

    drain();
    repeat (END_CYCLES) @(negedge clk);
    done <= 1'b1;
    repeat (2) @(negedge clk);

    $display("covered %0d frame items (%0d full-frame SysEx) across %0d rate settings",
             items_sent, full_sent, settings_used);
    $display("%0d MIDI bytes compared over four pacing phases and one long output hold-off",
             byte_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/mtc_pkg.sv
rtl/mtc_in_if.sv
rtl/mtc_out_if.sv
rtl/mtc_divider.sv
rtl/mtc_split.sv
rtl/mtc_fifo.sv
rtl/mtc_emitter.sv
rtl/midi_timecode_message_generator.sv
tb/sv/mtc_checker.sv
tb/sv/tb.sv
